// File: design/sal_pkg.sv
// Shared constants, codes and controller/datapath interface types for the suffix array builder
package sal_pkg;

   localparam int MAX_LEN_DEF  = 4096;
   localparam int ALPHABET_DEF = 26;

   localparam int OPC_W  = 2;
   localparam int SYM_W  = 5;
   localparam int RANK_W = 13;
   localparam int STAT_W = 2;
   localparam int POS_W  = 13;
   localparam int LCP_W  = 12;
   localparam int LEN_W  = 13;

   typedef logic [OPC_W-1:0]  opcode_type;
   typedef logic [STAT_W-1:0] status_type;

   localparam opcode_type OP_APPEND = 2'd0;
   localparam opcode_type OP_BUILD  = 2'd1;
   localparam opcode_type OP_READ   = 2'd2;
   localparam opcode_type OP_SPARE  = 2'd3;

   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_FULL    = 2'd1;
   localparam status_type ST_RANGE   = 2'd2;
   localparam status_type ST_UNBUILT = 2'd3;

   typedef logic [5:0] uop_type;

   localparam uop_type U_IDLE     = 6'd0;
   localparam uop_type U_APPEND   = 6'd1;
   localparam uop_type U_NOP      = 6'd2;
   localparam uop_type U_RD_ERR   = 6'd3;
   localparam uop_type U_RD_ISSUE = 6'd4;
   localparam uop_type U_RD_DATA  = 6'd5;
   localparam uop_type U_B0       = 6'd6;
   localparam uop_type U_I1       = 6'd7;
   localparam uop_type U_I2       = 6'd8;
   localparam uop_type U_CLR      = 6'd9;
   localparam uop_type U_C1       = 6'd10;
   localparam uop_type U_C2       = 6'd11;
   localparam uop_type U_C3       = 6'd12;
   localparam uop_type U_C4       = 6'd13;
   localparam uop_type U_P1       = 6'd14;
   localparam uop_type U_P2       = 6'd15;
   localparam uop_type U_L1       = 6'd16;
   localparam uop_type U_L2       = 6'd17;
   localparam uop_type U_L3       = 6'd18;
   localparam uop_type U_L4       = 6'd19;
   localparam uop_type U_DCHK     = 6'd20;
   localparam uop_type U_D1       = 6'd21;
   localparam uop_type U_D2A      = 6'd22;
   localparam uop_type U_D2B      = 6'd23;
   localparam uop_type U_R1       = 6'd24;
   localparam uop_type U_R2       = 6'd25;
   localparam uop_type U_R3       = 6'd26;
   localparam uop_type U_R4       = 6'd27;
   localparam uop_type U_R5       = 6'd28;
   localparam uop_type U_R6       = 6'd29;
   localparam uop_type U_R7       = 6'd30;
   localparam uop_type U_K1       = 6'd31;
   localparam uop_type U_K2       = 6'd32;
   localparam uop_type U_H1       = 6'd33;
   localparam uop_type U_H2       = 6'd34;
   localparam uop_type U_H3       = 6'd35;
   localparam uop_type U_H4       = 6'd36;
   localparam uop_type U_H5       = 6'd37;
   localparam uop_type U_H6       = 6'd38;
   localparam uop_type U_DONE     = 6'd39;

   typedef logic [1:0] isel_type;

   localparam isel_type I_ZERO = 2'd0;
   localparam isel_type I_ONE  = 2'd1;
   localparam isel_type I_N    = 2'd2;

   typedef struct packed {
      uop_type  op;
      logic     i_ld;
      isel_type i_sel;
   } cmd_type;

   typedef struct packed {
      logic rd_ok;
      logic n_zero;
      logic i_eq_n;
      logic i_eq_nb;
      logic i_eq_w;
      logic i_eq_1;
      logic more;
      logic r_le1;
      logic xy_in;
      logic sym_eq;
   } stat_type;

endpackage

// File: design/sal_controller.sv
// Sequencer for request decode, the prefix doubling sort passes and the LCP walk
module sal_controller import sal_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  opcode_type req_opcode,
   input  stat_type   stat,
   output logic       busy,
   output cmd_type    cmd
);

   uop_type state_ff, state_in;
   logic    first_ff, first_in;

   always_comb begin
      state_in  = state_ff;
      first_in  = first_ff;
      cmd.op    = state_ff;
      cmd.i_ld  = 1'b0;
      cmd.i_sel = I_ZERO;
      unique case (state_ff)
         U_IDLE: begin
            cmd.op = U_IDLE;
            if (start) begin
               unique case (req_opcode)
                  OP_APPEND: cmd.op = U_APPEND;
                  OP_BUILD: begin
                     cmd.op    = U_B0;
                     cmd.i_ld  = 1'b1;
                     cmd.i_sel = I_ONE;
                     first_in  = 1'b1;
                     state_in  = stat.n_zero ? U_DONE : U_I1;
                  end
                  OP_READ: begin
                     if (stat.rd_ok) begin
                        cmd.op   = U_RD_ISSUE;
                        state_in = U_RD_DATA;
                     end else begin
                        cmd.op = U_RD_ERR;
                     end
                  end
                  default: cmd.op = U_NOP;
               endcase
            end
         end
         U_RD_DATA: state_in = U_IDLE;
         U_I1:      state_in = U_I2;
         U_I2: begin
            if (stat.i_eq_n) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ZERO;
               state_in = U_CLR;
            end else begin
               state_in = U_I1;
            end
         end
         U_CLR: begin
            if (stat.i_eq_nb) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ONE;
               state_in = U_C1;
            end
         end
         U_C1: state_in = U_C2;
         U_C2: state_in = U_C3;
         U_C3: state_in = U_C4;
         U_C4: begin
            if (stat.i_eq_n) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ZERO;
               state_in = U_P1;
            end else begin
               state_in = U_C1;
            end
         end
         U_P1: state_in = U_P2;
         U_P2: begin
            if (stat.i_eq_nb) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_N;
               state_in = U_L1;
            end else begin
               state_in = U_P1;
            end
         end
         U_L1: state_in = U_L2;
         U_L2: state_in = U_L3;
         U_L3: state_in = U_L4;
         U_L4: begin
            if (!stat.i_eq_1) begin
               state_in = U_L1;
            end else if (first_ff) begin
               first_in = 1'b0;
               state_in = U_DCHK;
            end else begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ONE;
               state_in = U_R1;
            end
         end
         U_DCHK: begin
            cmd.i_ld = 1'b1;
            cmd.i_sel = I_ONE;
            state_in = stat.more ? U_D1 : U_H1;
         end
         U_D1: begin
            if (stat.i_eq_w) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ONE;
               state_in = U_D2A;
            end
         end
         U_D2A: state_in = U_D2B;
         U_D2B: begin
            if (stat.i_eq_n) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ZERO;
               state_in = U_CLR;
            end else begin
               state_in = U_D2A;
            end
         end
         U_R1: state_in = U_R2;
         U_R2: state_in = U_R3;
         U_R3: state_in = U_R4;
         U_R4: state_in = U_R5;
         U_R5: state_in = U_R6;
         U_R6: state_in = U_R7;
         U_R7: begin
            if (stat.i_eq_n) begin
               cmd.i_ld = 1'b1;
               cmd.i_sel = I_ONE;
               state_in = U_K1;
            end else begin
               state_in = U_R1;
            end
         end
         U_K1: state_in = U_K2;
         U_K2: state_in = stat.i_eq_n ? U_DCHK : U_K1;
         U_H1: state_in = U_H2;
         U_H2: begin
            if (stat.r_le1) state_in = stat.i_eq_n ? U_DONE : U_H1;
            else state_in = U_H3;
         end
         U_H3: state_in = U_H4;
         U_H4: begin
            if (stat.xy_in) state_in = U_H5;
            else state_in = stat.i_eq_n ? U_DONE : U_H1;
         end
         U_H5: state_in = U_H6;
         U_H6: begin
            if (stat.sym_eq) state_in = U_H4;
            else state_in = stat.i_eq_n ? U_DONE : U_H1;
         end
         U_DONE: state_in = U_IDLE;
         default: state_in = U_IDLE;
      endcase
   end

   assign busy = (state_ff != U_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= U_IDLE;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_build_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_BUILD) |=> busy)
      else $error("build request did not start the sequencer");
   a_read_two_cycles: assert property (@(posedge clock) disable iff (reset)
      (state_ff == U_RD_DATA) |=> !busy)
      else $error("read did not return to idle");
   a_append_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_APPEND) |=> !busy)
      else $error("append request made the sequencer busy");
`endif

endmodule

// File: design/sal_datapath.sv
// Text, suffix, rank, scratch, bucket and height memories with the counters that walk them
module sal_datapath import sal_pkg::*; #(
   parameter int MAX_LEN  = MAX_LEN_DEF,
   parameter int ALPHABET = ALPHABET_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic [RANK_W-1:0]  req_rank,
   output logic               rsp_strobe,
   output status_type         rsp_status,
   output logic [POS_W-1:0]   rsp_position,
   output logic [LCP_W-1:0]   rsp_lcp,
   output logic [LEN_W-1:0]   rsp_length
);

   localparam int VMAX   = (MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET;
   localparam int AW     = $clog2(MAX_LEN + 1);
   localparam int VW     = $clog2(VMAX + 1);
   localparam int CW     = VW + 1;
   localparam int SW     = $clog2(ALPHABET);
   localparam int HW     = $clog2(MAX_LEN);
   localparam int DEPTH  = MAX_LEN + 1;
   localparam int BDEPTH = VMAX + 1;

   logic [SW-1:0] txt_mem [DEPTH];
   logic [AW-1:0] sa_mem  [DEPTH];
   logic [VW-1:0] rk_mem  [DEPTH];
   logic [VW-1:0] sc_mem  [DEPTH];
   logic [AW-1:0] bk_mem  [BDEPTH];
   logic [HW-1:0] ht_mem  [DEPTH];

   logic [AW-1:0] txt_raddr, txt_waddr, sa_raddr, sa_waddr, rk_raddr, rk_waddr;
   logic [AW-1:0] sc_raddr, sc_waddr, ht_raddr, ht_waddr;
   logic [VW-1:0] bk_raddr, bk_waddr;
   logic          txt_we, sa_we, rk_we, sc_we, bk_we, ht_we;
   logic [SW-1:0] txt_wdata, txt_q_ff;
   logic [AW-1:0] sa_wdata, sa_q_ff, bk_wdata, bk_q_ff;
   logic [VW-1:0] rk_wdata, rk_q_ff, sc_wdata, sc_q_ff;
   logic [HW-1:0] ht_wdata, ht_q_ff;

   logic [AW-1:0] len_ff, len_in, nlen;
   logic          built_ff, built_in;
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, w_ff, w_in, cnt_ff, cnt_in, acc_ff, acc_in;
   logic [CW-1:0] pre_ff, pre_in, x_ff, x_in, y_ff, y_in;
   logic [VW-1:0] p_ff, p_in, r_ff, r_in, ra_ff, ra_in, raw_ff, raw_in;
   logic [AW-1:0] a_ff, a_in, b_ff, b_in;
   logic          pgt_ff, pgt_in, dif_ff, dif_in, r1_ff, r1_in;
   logic [SW-1:0] tx_ff, tx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [POS_W-1:0]   rsp_pos_ff, rsp_pos_in;
   logic [LCP_W-1:0]   rsp_lcp_ff, rsp_lcp_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   logic [CW-1:0] nc, nb, aw_sum, bw_sum, cnt_new, acc_sum;
   logic [VW-1:0] rk_val, rbw;
   logic [SW-1:0] sym_sat;

   assign nc      = CW'(len_ff);
   assign nb      = (nc > CW'(ALPHABET)) ? nc : CW'(ALPHABET);
   assign aw_sum  = CW'(a_ff) + w_ff;
   assign bw_sum  = CW'(b_ff) + w_ff;
   assign rk_val  = pgt_ff ? '0 : rk_q_ff;
   assign rbw     = (bw_sum > nc) ? '0 : rk_q_ff;
   assign cnt_new = cnt_ff + CW'(dif_ff || (raw_ff != rbw));
   assign acc_sum = acc_ff + CW'(bk_q_ff);
   assign sym_sat = (32'(req_symbol) >= 32'(ALPHABET)) ? SW'(ALPHABET - 1) : SW'(req_symbol);
   assign nlen    = built_ff ? '0 : len_ff;

   always_comb begin
      stat.rd_ok   = built_ff && (req_rank != '0) && (32'(req_rank) <= 32'(len_ff));
      stat.n_zero  = (len_ff == '0);
      stat.i_eq_n  = (i_ff == nc);
      stat.i_eq_nb = (i_ff == nb);
      stat.i_eq_w  = (i_ff == w_ff);
      stat.i_eq_1  = (i_ff == CW'(1));
      stat.more    = (w_ff < nc) && (cnt_ff < nc);
      stat.r_le1   = (rk_q_ff <= VW'(1));
      stat.xy_in   = (x_ff <= nc) && (y_ff <= nc);
      stat.sym_eq  = (tx_ff == txt_q_ff);
   end

   always_comb begin
      txt_raddr = '0; txt_we = 1'b0; txt_waddr = '0; txt_wdata = '0;
      sa_raddr  = '0; sa_we  = 1'b0; sa_waddr  = '0; sa_wdata  = '0;
      rk_raddr  = '0; rk_we  = 1'b0; rk_waddr  = '0; rk_wdata  = '0;
      sc_raddr  = '0; sc_we  = 1'b0; sc_waddr  = '0; sc_wdata  = '0;
      bk_raddr  = '0; bk_we  = 1'b0; bk_waddr  = '0; bk_wdata  = '0;
      ht_raddr  = '0; ht_we  = 1'b0; ht_waddr  = '0; ht_wdata  = '0;
      len_in = len_ff;  built_in = built_ff;
      i_in = i_ff;  j_in = j_ff;  w_in = w_ff;  cnt_in = cnt_ff;  acc_in = acc_ff;
      pre_in = pre_ff;  x_in = x_ff;  y_in = y_ff;
      p_in = p_ff;  r_in = r_ff;  ra_in = ra_ff;  raw_in = raw_ff;
      a_in = a_ff;  b_in = b_ff;  pgt_in = pgt_ff;  dif_in = dif_ff;
      r1_in = r1_ff;  tx_in = tx_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_OK;
      rsp_pos_in    = '0;
      rsp_lcp_in    = '0;
      rsp_len_in    = LEN_W'(len_ff);

      unique case (cmd.op) inside
         U_APPEND: begin
            built_in     = 1'b0;
            rsp_valid_in = 1'b1;
            if (nlen >= AW'(MAX_LEN)) begin
               len_in        = nlen;
               rsp_status_in = ST_FULL;
            end else begin
               txt_we    = 1'b1;
               txt_waddr = nlen + AW'(1);
               txt_wdata = sym_sat;
               len_in    = nlen + AW'(1);
            end
            rsp_len_in = LEN_W'(len_in);
         end
         U_NOP: rsp_valid_in = 1'b1;
         U_RD_ERR: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = built_ff ? ST_RANGE : ST_UNBUILT;
         end
         U_RD_ISSUE: begin
            sa_raddr = AW'(req_rank);
            ht_raddr = AW'(req_rank);
            r1_in    = (req_rank == RANK_W'(1));
         end
         U_RD_DATA: begin
            rsp_valid_in = 1'b1;
            rsp_pos_in   = POS_W'(sa_q_ff);
            rsp_lcp_in   = r1_ff ? '0 : LCP_W'(ht_q_ff);
         end
         U_B0: begin
            sa_we  = 1'b1;
            rk_we  = 1'b1;
            w_in   = CW'(1);
            cnt_in = '0;
         end
         U_I1: txt_raddr = AW'(i_ff);
         U_I2: begin
            sc_we    = 1'b1;
            sc_waddr = AW'(i_ff);
            sc_wdata = VW'(i_ff);
            rk_we    = 1'b1;
            rk_waddr = AW'(i_ff);
            rk_wdata = VW'(txt_q_ff) + VW'(1);
            i_in     = i_ff + CW'(1);
         end
         U_CLR: begin
            bk_we    = 1'b1;
            bk_waddr = VW'(i_ff);
            acc_in   = '0;
            i_in     = i_ff + CW'(1);
         end
         U_C1, U_L1: sc_raddr = AW'(i_ff);
         U_C2, U_L2: begin
            p_in     = sc_q_ff;
            pgt_in   = CW'(sc_q_ff) > nc;
            rk_raddr = AW'(sc_q_ff);
         end
         U_C3, U_L3: begin
            r_in     = rk_val;
            bk_raddr = rk_val;
         end
         U_C4: begin
            bk_we    = 1'b1;
            bk_waddr = r_ff;
            bk_wdata = bk_q_ff + AW'(1);
            i_in     = i_ff + CW'(1);
         end
         U_P1: bk_raddr = VW'(i_ff);
         U_P2: begin
            bk_we    = 1'b1;
            bk_waddr = VW'(i_ff);
            bk_wdata = AW'(acc_sum);
            acc_in   = acc_sum;
            i_in     = i_ff + CW'(1);
         end
         U_L4: begin
            sa_we    = 1'b1;
            sa_waddr = bk_q_ff;
            sa_wdata = AW'(p_ff);
            bk_we    = 1'b1;
            bk_waddr = r_ff;
            bk_wdata = bk_q_ff - AW'(1);
            i_in     = i_ff - CW'(1);
            if (stat.i_eq_1) cnt_in = '0;
         end
         U_DCHK: begin
            j_in   = w_ff;
            pre_in = '0;
         end
         U_D1: begin
            sc_we    = 1'b1;
            sc_waddr = AW'(i_ff);
            sc_wdata = VW'(nc - w_ff + i_ff);
            i_in     = i_ff + CW'(1);
         end
         U_D2A: sa_raddr = AW'(i_ff);
         U_D2B: begin
            // suffixes starting past w are entered shifted down by w, in second-key order
            if (CW'(sa_q_ff) > w_ff) begin
               sc_we    = 1'b1;
               sc_waddr = AW'(j_ff + CW'(1));
               sc_wdata = VW'(CW'(sa_q_ff) - w_ff);
               j_in     = j_ff + CW'(1);
            end
            i_in = i_ff + CW'(1);
         end
         U_R1: sa_raddr = AW'(i_ff - CW'(1));
         U_R2: begin
            a_in     = sa_q_ff;
            sa_raddr = AW'(i_ff);
         end
         U_R3: begin
            b_in     = sa_q_ff;
            rk_raddr = a_ff;
         end
         U_R4: begin
            ra_in    = rk_q_ff;
            rk_raddr = b_ff;
         end
         U_R5: begin
            dif_in   = (ra_ff != rk_q_ff);
            rk_raddr = AW'(aw_sum);
         end
         U_R6: begin
            raw_in   = (aw_sum > nc) ? '0 : rk_q_ff;
            rk_raddr = AW'(bw_sum);
         end
         U_R7: begin
            sc_we    = 1'b1;
            sc_waddr = b_ff;
            sc_wdata = VW'(cnt_new);
            cnt_in   = cnt_new;
            i_in     = i_ff + CW'(1);
         end
         U_K1: sc_raddr = AW'(i_ff);
         U_K2: begin
            rk_we    = 1'b1;
            rk_waddr = AW'(i_ff);
            rk_wdata = sc_q_ff;
            i_in     = i_ff + CW'(1);
            if (stat.i_eq_n) w_in = w_ff << 1;
         end
         U_H1: rk_raddr = AW'(i_ff);
         U_H2: begin
            r_in = rk_q_ff;
            if (stat.r_le1) begin
               pre_in = '0;
               i_in   = i_ff + CW'(1);
            end else begin
               pre_in   = (pre_ff != '0) ? pre_ff - CW'(1) : '0;
               sa_raddr = AW'(rk_q_ff - VW'(1));
            end
         end
         U_H3: begin
            x_in = CW'(sa_q_ff) + pre_ff;
            y_in = i_ff + pre_ff;
         end
         U_H4: begin
            if (stat.xy_in) begin
               txt_raddr = AW'(x_ff);
            end else begin
               ht_we    = 1'b1;
               ht_waddr = AW'(r_ff);
               ht_wdata = HW'(pre_ff);
               i_in     = i_ff + CW'(1);
            end
         end
         U_H5: begin
            tx_in     = txt_q_ff;
            txt_raddr = AW'(y_ff);
         end
         U_H6: begin
            if (stat.sym_eq) begin
               x_in   = x_ff + CW'(1);
               y_in   = y_ff + CW'(1);
               pre_in = pre_ff + CW'(1);
            end else begin
               ht_we    = 1'b1;
               ht_waddr = AW'(r_ff);
               ht_wdata = HW'(pre_ff);
               i_in     = i_ff + CW'(1);
            end
         end
         U_DONE: begin
            built_in     = 1'b1;
            rsp_valid_in = 1'b1;
         end
         default: ;
      endcase

      if (cmd.i_ld) begin
         case (cmd.i_sel)
            I_ONE:   i_in = CW'(1);
            I_N:     i_in = nc;
            default: i_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (txt_we) txt_mem[txt_waddr] <= txt_wdata;
      txt_q_ff <= txt_mem[txt_raddr];
   end

   always_ff @(posedge clock) begin
      if (sa_we) sa_mem[sa_waddr] <= sa_wdata;
      sa_q_ff <= sa_mem[sa_raddr];
   end

   always_ff @(posedge clock) begin
      if (rk_we) rk_mem[rk_waddr] <= rk_wdata;
      rk_q_ff <= rk_mem[rk_raddr];
   end

   always_ff @(posedge clock) begin
      if (sc_we) sc_mem[sc_waddr] <= sc_wdata;
      sc_q_ff <= sc_mem[sc_raddr];
   end

   always_ff @(posedge clock) begin
      if (bk_we) bk_mem[bk_waddr] <= bk_wdata;
      bk_q_ff <= bk_mem[bk_raddr];
   end

   always_ff @(posedge clock) begin
      if (ht_we) ht_mem[ht_waddr] <= ht_wdata;
      ht_q_ff <= ht_mem[ht_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         built_ff     <= built_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in;  j_ff <= j_in;  w_ff <= w_in;  cnt_ff <= cnt_in;  acc_ff <= acc_in;
      pre_ff <= pre_in;  x_ff <= x_in;  y_ff <= y_in;
      p_ff <= p_in;  r_ff <= r_in;  ra_ff <= ra_in;  raw_ff <= raw_in;
      a_ff <= a_in;  b_ff <= b_in;  pgt_ff <= pgt_in;  dif_ff <= dif_in;
      r1_ff <= r1_in;  tx_ff <= tx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_lcp_ff    <= rsp_lcp_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_strobe   = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_pos_ff;
   assign rsp_lcp      = rsp_lcp_ff;
   assign rsp_length   = rsp_len_ff;

`ifndef NO_ASSERTIONS
   a_err_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != ST_OK) |-> (rsp_pos_ff == '0 && rsp_lcp_ff == '0))
      else $error("error response carries position or lcp");
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= AW'(MAX_LEN))
      else $error("loaded length beyond capacity");
   a_full_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_len_ff == LEN_W'(MAX_LEN)))
      else $error("full status without a full store");
`endif

endmodule

// File: design/suffix_array_lcp_builder.sv
// Top level of the suffix array and LCP builder
//
// channel   direction  handshake                 payload
// request   in         start high, busy low      req_opcode, req_symbol, req_rank
// response  out        rsp_strobe, one cycle     rsp_status, rsp_position, rsp_lcp, rsp_length
//
// Append and any rejected request: response in the next cycle, busy stays low.
// Valid read: a registered memory read of suffix and height, then the registered response.
// Build: busy while the memory walks run for each counting-sort pass, for each doubling pass
//   (second-key order, rerank, rank copy) and for the LCP scan over each position and its
//   matched symbols.
// Reset is synchronous; memories hold no reset and are filled by appends and builds.
// The receiver cannot stall; each response appears exactly once.
module suffix_array_lcp_builder import sal_pkg::*; #(
   parameter int MAX_LEN  = MAX_LEN_DEF,
   parameter int ALPHABET = ALPHABET_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  opcode_type         req_opcode,
   input  logic [SYM_W-1:0]   req_symbol,
   input  logic [RANK_W-1:0]  req_rank,
   output logic               rsp_strobe,
   output status_type         rsp_status,
   output logic [POS_W-1:0]   rsp_position,
   output logic [LCP_W-1:0]   rsp_lcp,
   output logic [LEN_W-1:0]   rsp_length
);

   cmd_type  cmd;
   stat_type stat;

   sal_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd)
   );

   sal_datapath #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_symbol   (req_symbol),
      .req_rank     (req_rank),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_position (rsp_position),
      .rsp_lcp      (rsp_lcp),
      .rsp_length   (rsp_length)
   );

endmodule

// File: tb/suffix_array_lcp_builder_tb.sv
// Self-checking testbench for the suffix array and LCP builder
module suffix_array_lcp_builder_tb import sal_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXN = MAX_LEN_DEF;
   localparam int ALPH = ALPHABET_DEF;
   localparam int IDLE_LIMIT = 4000000;

   typedef struct {
      status_type       status;
      logic [POS_W-1:0] position;
      logic [LCP_W-1:0] lcp;
      logic [LEN_W-1:0] length;
   } rsp_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   opcode_type         req_opcode = OP_APPEND;
   logic [SYM_W-1:0]   req_symbol = '0;
   logic [RANK_W-1:0]  req_rank = '0;
   logic               rsp_strobe;
   status_type         rsp_status;
   logic [POS_W-1:0]   rsp_position;
   logic [LCP_W-1:0]   rsp_lcp;
   logic [LEN_W-1:0]   rsp_length;

   suffix_array_lcp_builder uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_symbol(req_symbol), .req_rank(req_rank),
      .rsp_strobe(rsp_strobe), .rsp_status(rsp_status), .rsp_position(rsp_position),
      .rsp_lcp(rsp_lcp), .rsp_length(rsp_length)
   );

   always #5 clock = ~clock;

   // predictor state
   int text_mem [0:MAXN+1];
   int order_mem [0:MAXN+1];
   int rank_mem [0:MAXN+1];
   int temp_mem [0:MAXN+1];
   int bucket_mem [0:MAXN+ALPH+2];
   int height_mem [0:MAXN+1];
   int loaded_len = 0;
   bit sa_built = 0;

   rsp_item_type pending_rsp [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int items_sent = 0;

   function automatic int rank_of(int p, int n);
      if (p > n || p > MAXN) return 0;
      return rank_mem[p];
   endfunction

   function automatic void bucket_sort(int n);
      int nb, p, r;
      nb = (n > ALPH) ? n : ALPH;
      for (int i = 0; i <= MAXN + ALPH + 2; i++) bucket_mem[i] = 0;
      for (int i = 1; i <= n; i++) bucket_mem[rank_of(temp_mem[i], n)]++;
      for (int i = 1; i <= nb; i++) bucket_mem[i] += bucket_mem[i-1];
      for (int i = n; i >= 1; i--) begin
         p = temp_mem[i];
         r = rank_of(p, n);
         order_mem[bucket_mem[r]] = p;
         bucket_mem[r]--;
      end
   endfunction

   function automatic void build_suffix_array();
      int n, cnt, pre, j, a, b, r, x, y;
      n = loaded_len;
      order_mem[0] = 0;
      rank_mem[0] = 0;
      for (int i = 1; i <= n; i++) begin
         temp_mem[i] = i;
         rank_mem[i] = text_mem[i] + 1;
      end
      bucket_sort(n);
      cnt = 0;
      for (int w = 1; w < n && cnt < n; w = w << 1) begin
         j = w;
         for (int i = 1; i <= w; i++) temp_mem[i] = n - w + i;
         for (int i = 1; i <= n; i++)
            if (order_mem[i] > w) begin
               j++;
               temp_mem[j] = order_mem[i] - w;
            end
         bucket_sort(n);
         cnt = 0;
         for (int i = 1; i <= n; i++) begin
            a = order_mem[i-1];
            b = order_mem[i];
            if (rank_of(a, n) != rank_of(b, n) || rank_of(a + w, n) != rank_of(b + w, n))
               cnt++;
            temp_mem[b] = cnt;
         end
         for (int i = 1; i <= n; i++) rank_mem[i] = temp_mem[i];
      end
      // Kasai height scan
      pre = 0;
      for (int i = 1; i <= n; i++) begin
         r = rank_mem[i];
         if (pre > 0) pre--;
         if (r <= 1) begin
            pre = 0;
         end else begin
            x = order_mem[r-1] + pre;
            y = i + pre;
            while (x <= n && y <= n && text_mem[x] == text_mem[y]) begin
               x++;
               y++;
               pre++;
            end
            height_mem[r] = pre;
         end
      end
      height_mem[1] = 0;
      sa_built = 1;
   endfunction

   function automatic rsp_item_type predict_response(opcode_type op, int sym, int rk);
      rsp_item_type e;
      e.status = ST_OK;
      e.position = '0;
      e.lcp = '0;
      if (op == OP_APPEND) begin
         if (sa_built) begin
            sa_built = 0;
            loaded_len = 0;
         end
         if (loaded_len >= MAXN) begin
            e.status = ST_FULL;
         end else begin
            if (sym >= ALPH) sym = ALPH - 1;
            loaded_len++;
            text_mem[loaded_len] = sym;
         end
      end else if (op == OP_BUILD) begin
         build_suffix_array();
      end else if (op == OP_READ) begin
         if (!sa_built) e.status = ST_UNBUILT;
         else if (rk == 0 || rk > loaded_len) e.status = ST_RANGE;
         else begin
            e.position = POS_W'(order_mem[rk]);
            e.lcp = (rk == 1) ? '0 : LCP_W'(height_mem[rk]);
         end
      end
      e.length = LEN_W'(loaded_len);
      return e;
   endfunction

   // start stays high across back-to-back requests
   task automatic send_request(opcode_type op, int sym, int rk);
      logic [SYM_W-1:0]  sym_bits;
      logic [RANK_W-1:0] rank_bits;
      sym_bits = SYM_W'(sym);
      rank_bits = RANK_W'(rk);
      start <= 1'b1;
      req_opcode <= op;
      req_symbol <= sym_bits;
      req_rank <= rank_bits;
      do @(posedge clock); while (busy);
      pending_rsp.insert(pending_rsp.size(),
                         predict_response(op, int'(sym_bits), int'(rank_bits)));
      items_sent++;
   endtask

   task automatic pause(int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   int burst_left = 0;
   task automatic paced_request(opcode_type op, int sym, int rk);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
      burst_left--;
      send_request(op, sym, rk);
   endtask

   task automatic read_all_ranks(int n);
      for (int r = 1; r <= n; r++) paced_request(OP_READ, $urandom, r);
   endtask

   task automatic test_directed();
      send_request(OP_READ, 0, 1);          // before any build
      send_request(OP_BUILD, 0, 0);         // empty string
      send_request(OP_READ, 0, 1);
      send_request(OP_READ, 0, 0);
      send_request(OP_SPARE, 31, 8191);     // unused opcode
      send_request(OP_APPEND, 0, 0);
      send_request(OP_APPEND, 25, 0);
      send_request(OP_APPEND, 31, 0);       // saturates to z
      send_request(OP_APPEND, 0, 0);
      send_request(OP_APPEND, 26, 8191);
      send_request(OP_READ, 0, 1);          // appended, not built
      send_request(OP_BUILD, 0, 0);
      read_all_ranks(5);
      send_request(OP_READ, 0, 0);
      send_request(OP_READ, 0, 6);
      send_request(OP_READ, 0, 8191);
      send_request(OP_BUILD, 0, 0);         // rebuild same string
      send_request(OP_READ, 0, 3);
      send_request(OP_APPEND, 1, 0);        // starts a new string
      send_request(OP_READ, 0, 1);
      drain();
   endtask

   task automatic test_full_store();
      for (int i = 0; i < MAXN; i++) send_request(OP_APPEND, $urandom_range(0, 31), 0);
      send_request(OP_APPEND, 3, 0);        // dropped
      send_request(OP_APPEND, 7, 4096);
      send_request(OP_BUILD, 0, 0);
      send_request(OP_READ, 0, 1);
      send_request(OP_READ, 0, MAXN);
      send_request(OP_READ, 0, MAXN + 1);
      for (int i = 0; i < 8; i++) send_request(OP_READ, 0, $urandom_range(1, MAXN));
      drain();
   endtask

   task automatic test_random();
      int n, alph, k;
      while (items_sent < 1950 + MAXN) begin
         k = $urandom_range(0, 9);
         if (k == 0) begin
            case ($urandom_range(0, 3))
               0: paced_request(OP_SPARE, $urandom, $urandom);
               1: paced_request(OP_READ, $urandom, $urandom);
               2: paced_request(OP_BUILD, $urandom, $urandom);
               default: paced_request(OP_APPEND, $urandom_range(0, 31), $urandom);
            endcase
         end else begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
            alph = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 3) : 32;
            for (int i = 0; i < n; i++) paced_request(OP_APPEND, $urandom_range(0, alph - 1),
                                                     $urandom);
            if ($urandom_range(0, 7) == 0) paced_request(OP_READ, 0, $urandom_range(1, n));
            paced_request(OP_BUILD, $urandom, $urandom);
            if (n <= 24) read_all_ranks(n);
            else for (int i = 0; i < 16; i++) paced_request(OP_READ, 0, $urandom_range(1, n));
            if ($urandom_range(0, 3) == 0) paced_request(OP_READ, 0, $urandom_range(n + 1, 8191));
            if ($urandom_range(0, 15) == 0) drain();
         end
      end
      drain();
   endtask

   always @(posedge clock) begin
      rsp_item_type e;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response status=%0d pos=%0d",
                                           rsp_status, rsp_position);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status !== e.status || rsp_position !== e.position ||
                rsp_lcp !== e.lcp || rsp_length !== e.length) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp st=%0d pos=%0d lcp=%0d len=%0d ",
                           e.status, e.position, e.lcp, e.length,
                           "got st=%0d pos=%0d lcp=%0d len=%0d",
                           rsp_status, rsp_position, rsp_lcp, rsp_length);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("suffix_array_lcp_builder_tb: FAIL");
         $finish;
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_random();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0)
         $display("suffix_array_lcp_builder_tb: PASS");
      else
         $display("suffix_array_lcp_builder_tb: FAIL");
      $finish;
   end
endmodule
